@@ rtl/core/pfr_pkg.sv @@
// Shared types and constants for the page frame replacement unit.
// No dependencies.
package pfr_pkg;

  localparam int unsigned FRAMES     = 16;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned PAGE_W     = 20;
  localparam int unsigned IDX_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CNT_W      = $clog2(FRAMES + 1);
  localparam int unsigned AGE_W      = IDX_W;
  localparam int unsigned CFG_W      = 5;

  localparam logic [0:0] REG_FRAMES = 1'b0;
  localparam logic [0:0] REG_POLICY = 1'b1;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              dirty;
    logic              used;
    logic [AGE_W-1:0]  age;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CLK_RD,
    ST_CLK_EV,
    ST_UPD,
    ST_OUT
  } state_e;

endpackage

@@ rtl/core/page_frame_replacement.sv @@
// Page frame replacement unit: frame table in one synchronous RAM, LRU or clock.
// Depends on pfr_pkg.
// Sequence: the idle state takes the beat, then a lookup sweep reads each filled
// frame, a clock eviction reads and tests the frame under the hand per step, an
// update sweep rewrites the frames up to lim (at most frames_in_use) and the
// result is loaded into the output register. One item in flight: a new access is
// taken only once the result of the last one is loaded, as the single RAM read
// port serves every step.
// Reset clears fill count, clock hand and control state and restores the config; the RAM needs no clearing.
module page_frame_replacement (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,   // [31:0] address
  input  logic        s_tuser_i,   // [0] is_write
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o,   // [0] hit, [4:1] frame, [5] victim_valid,
                                   // [25:6] evict_page, [26] victim_dirty
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pfr_pkg::*;

  entry_t mem_q [FRAMES];
  entry_t rd_q;

  state_e state_q, state_d;
  logic [CFG_W-1:0]  fiu_q;
  logic              policy_q;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [IDX_W-1:0]  hand_q, hand_d;
  logic [PAGE_W-1:0] page_q;
  logic              wr_q;
  logic [CNT_W-1:0]  idx_q, idx_d, lim_q, lim_d;
  logic              pend_q, pend_d;
  logic [IDX_W-1:0]  ridx_q, ridx_d;
  logic              hit_q, hit_d, fresh_q, fresh_d, evict_q, evict_d;
  logic [IDX_W-1:0]  f_q, f_d, best_q, best_d;
  logic [AGE_W-1:0]  old_q, old_d, bage_q, bage_d;
  logic [PAGE_W-1:0] vpage_q, vpage_d;
  logic              vdirty_q, vdirty_d;
  logic              ovalid_q;
  logic [31:0]       odata_q;

  logic [CNT_W-1:0] n, r;
  logic             full;
  logic             rd_en, we;
  logic [IDX_W-1:0] raddr, waddr;
  entry_t           wdata;
  logic [IDX_W-1:0] hand_nx;

  always_comb begin
    if (fiu_q == '0) n = CNT_W'(1);
    else if (CNT_W'(fiu_q) > CNT_W'(FRAMES) || fiu_q > CFG_W'(FRAMES)) n = CNT_W'(FRAMES);
    else n = CNT_W'(fiu_q);
    r    = (fill_q < n) ? fill_q : n;
    full = (fill_q >= n);
  end

  assign hand_nx = ((CNT_W'(hand_q) + CNT_W'(1)) >= n) ? '0 : hand_q + IDX_W'(1);

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_POLICY) ? {31'd0, policy_q} : {27'd0, fiu_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fiu_q    <= CFG_W'(FRAMES);
      policy_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_FRAMES) fiu_q <= pwdata[CFG_W-1:0];
      else policy_q <= pwdata[0];
    end
  end

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = ovalid_q;
  assign m_tdata_o  = odata_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (s_tvalid_i) state_d = ST_SCAN;
      ST_SCAN: begin
        if (idx_q >= lim_q && !pend_q) begin
          if (hit_q || !full) state_d = ST_UPD;
          else if (policy_q) state_d = ST_CLK_RD;
          else state_d = ST_UPD;
        end
      end
      ST_CLK_RD: state_d = ST_CLK_EV;
      ST_CLK_EV: state_d = rd_q.used ? ST_CLK_RD : ST_UPD;
      ST_UPD:    if (idx_q >= lim_q && !pend_q) state_d = ST_OUT;
      ST_OUT:    if (!ovalid_q || m_tready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    fill_d = fill_q;  hand_d = hand_q;
    idx_d = idx_q;    lim_d = lim_q;    pend_d = 1'b0;  ridx_d = idx_q[IDX_W-1:0];
    hit_d = hit_q;    fresh_d = fresh_q; evict_d = evict_q;
    f_d = f_q;        best_d = best_q;  old_d = old_q;  bage_d = bage_q;
    vpage_d = vpage_q; vdirty_d = vdirty_q;
    rd_en = 1'b0;     raddr = idx_q[IDX_W-1:0];
    we = 1'b0;        waddr = ridx_q;   wdata = rd_q;
    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0; lim_d = r; hit_d = 1'b0; fresh_d = 1'b0; evict_d = 1'b0;
        best_d = '0; bage_d = '0; vpage_d = '0; vdirty_d = 1'b0;
      end
      ST_SCAN: begin
        if (idx_q < lim_q) begin
          rd_en = 1'b1; pend_d = 1'b1; idx_d = idx_q + CNT_W'(1);
        end
        if (pend_q) begin
          if (!hit_q && rd_q.page == page_q) begin
            hit_d = 1'b1; f_d = ridx_q; old_d = rd_q.age;
          end
          if (ridx_q == '0 || rd_q.age > bage_q) begin
            best_d = ridx_q; bage_d = rd_q.age;
          end
        end
        if (idx_q >= lim_q && !pend_q) begin
          idx_d = '0;
          if (hit_q) lim_d = r;
          else if (!full) begin
            fresh_d = 1'b1; f_d = fill_q[IDX_W-1:0];
            lim_d = fill_q + CNT_W'(1); fill_d = fill_q + CNT_W'(1);
          end else begin
            evict_d = 1'b1; lim_d = n; f_d = best_q; old_d = bage_q;
            // wrap the hand only when the sweep is about to use it
            if (policy_q && CNT_W'(hand_q) >= n) hand_d = '0;
          end
        end
      end
      ST_CLK_RD: begin
        rd_en = 1'b1; raddr = hand_q;
      end
      ST_CLK_EV: begin
        hand_d = hand_nx;
        if (rd_q.used) begin
          // second chance: clear use bit and move on
          we = 1'b1; waddr = hand_q; wdata = rd_q; wdata.used = 1'b0;
        end else begin
          f_d = hand_q; old_d = rd_q.age;
        end
      end
      ST_UPD: begin
        if (idx_q < lim_q) begin
          rd_en = 1'b1; pend_d = 1'b1; idx_d = idx_q + CNT_W'(1);
        end
        if (pend_q) begin
          we = 1'b1; wdata = rd_q;
          if (ridx_q == f_q) begin
            vpage_d = rd_q.page; vdirty_d = rd_q.dirty;
            wdata.used = 1'b1; wdata.age = '0;
            if (hit_q) wdata.dirty = rd_q.dirty | wr_q;
            else begin
              wdata.page = page_q; wdata.dirty = wr_q;
            end
          end else if ((fresh_q || rd_q.age < old_q) &&
                       rd_q.age < AGE_W'(FRAMES - 1)) begin
            wdata.age = rd_q.age + AGE_W'(1);
          end
        end
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (rd_en) rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_tvalid_i) begin
      page_q <= s_tdata_i[PAGE_SHIFT +: PAGE_W];
      wr_q   <= s_tuser_i;
    end
    lim_q <= lim_d; ridx_q <= ridx_d;
    hit_q <= hit_d; fresh_q <= fresh_d; evict_q <= evict_d;
    f_q <= f_d; best_q <= best_d; old_q <= old_d; bage_q <= bage_d;
    vpage_q <= vpage_d; vdirty_q <= vdirty_d;
    if (state_q == ST_OUT && (!ovalid_q || m_tready_i)) begin
      odata_q <= {5'd0, evict_q & vdirty_q, evict_q ? vpage_q : {PAGE_W{1'b0}},
                  evict_q, f_q, hit_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      hand_q   <= '0;
      idx_q    <= '0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      hand_q  <= hand_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      if (state_q == ST_OUT && (!ovalid_q || m_tready_i)) ovalid_q <= 1'b1;
      else if (m_tready_i) ovalid_q <= 1'b0;
    end
  end

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(FRAMES)) else $error("fill count beyond frame table");
  a_hand_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLK_EV |-> CNT_W'(hand_q) < n) else $error("clock hand outside managed frames");
  a_victim_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tdata_o[5] |-> !m_tdata_o[0]) else $error("victim reported on a hit");
  a_pend_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> state_q == ST_SCAN || state_q == ST_UPD) else $error("stray RAM read");

endmodule

@@ dv/pfr_checker.sv @@
// Checker for the page frame replacement unit: tracks register writes, predicts each
// access result from its own frame table copy and compares it against the output stream.
// Depends on pfr_pkg.
`timescale 1ns / 1ps

module pfr_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,   // [31:0] address
  input  logic        s_tuser_i,   // [0] is_write
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,   // [0] hit, [4:1] frame, [5] victim_valid,
                                   // [25:6] evict_page, [26] victim_dirty
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          pending_o,
  output int          errors_o
);
  import pfr_pkg::*;

  typedef struct packed {
    logic [4:0]        pad;
    logic              victim_dirty;
    logic [PAGE_W-1:0] evict_page;
    logic              victim_valid;
    logic [IDX_W-1:0]  frame;
    logic              hit;
  } access_res_t;

  logic [PAGE_W-1:0] page_tbl [FRAMES];
  logic              dirty_tbl[FRAMES];
  logic              use_tbl  [FRAMES];
  int                age_tbl  [FRAMES];
  int                fill_cnt;
  int                hand;
  logic [CFG_W-1:0]  cfg_frames;
  logic              cfg_policy;
  access_res_t       expected_q[$];
  int                errors;

  assign pending_o = expected_q.size();
  assign errors_o  = errors;

  // Move frame f to age zero and push younger resident frames back by one.
  task automatic promote(input int f, input int r, input bit fresh);
    int old;
    old = fresh ? FRAMES + 1 : age_tbl[f];
    for (int i = 0; i < r; i++)
      if (i != f && age_tbl[i] < old && age_tbl[i] < FRAMES - 1) age_tbl[i]++;
    age_tbl[f] = 0;
    use_tbl[f] = 1'b1;
  endtask

  task automatic predict_access(input logic [31:0] addr, input logic wr);
    access_res_t e;
    logic [PAGE_W-1:0] pg;
    int n, r, f, best;
    bit found, done;
    pg = addr[31:PAGE_SHIFT];
    n = cfg_frames;
    if (n == 0) n = 1;
    if (n > FRAMES) n = FRAMES;
    r = (fill_cnt < n) ? fill_cnt : n;
    e = '0;
    found = 0;
    f = 0;
    for (int i = 0; i < r; i++)
      if (!found && page_tbl[i] == pg) begin
        found = 1;
        f = i;
      end
    if (found) begin
      promote(f, r, 0);
      if (wr) dirty_tbl[f] = 1'b1;
      e.hit = 1'b1;
    end else if (fill_cnt < n) begin
      f = fill_cnt;
      fill_cnt++;
      page_tbl[f]  = pg;
      dirty_tbl[f] = wr;
      promote(f, f + 1, 1);
    end else begin
      if (cfg_policy) begin
        // Second-chance sweep: clear use bits until an unused frame turns up.
        if (hand >= n) hand = 0;
        done = 0;
        best = 0;
        for (int k = 0; k <= 2 * n; k++) begin
          int h;
          if (!done) begin
            h = hand;
            hand = (h + 1 >= n) ? 0 : h + 1;
            if (use_tbl[h]) use_tbl[h] = 1'b0;
            else begin
              best = h;
              done = 1;
            end
          end
        end
      end else begin
        best = 0;
        for (int i = 1; i < n; i++) if (age_tbl[i] > age_tbl[best]) best = i;
      end
      f = best;
      e.victim_valid = 1'b1;
      e.evict_page   = page_tbl[f];
      e.victim_dirty = dirty_tbl[f];
      page_tbl[f]  = pg;
      dirty_tbl[f] = wr;
      promote(f, n, 0);
    end
    e.frame = f[IDX_W-1:0];
    expected_q.push_back(e);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    access_res_t exp_r, act_r;
    if (!rst_ni) begin
      for (int i = 0; i < FRAMES; i++) begin
        page_tbl[i]  = '0;
        dirty_tbl[i] = 1'b0;
        use_tbl[i]   = 1'b0;
        age_tbl[i]   = 0;
      end
      fill_cnt   = 0;
      hand       = 0;
      cfg_frames = CFG_W'(FRAMES);
      cfg_policy = 1'b0;
      expected_q.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2:2] == REG_FRAMES) cfg_frames = pwdata[CFG_W-1:0];
        else if (paddr[2:2] == REG_POLICY) cfg_policy = pwdata[0];
      end
      if (s_tvalid_i && s_tready_i) predict_access(s_tdata_i, s_tuser_i);
      if (m_tvalid_i && m_tready_i) begin
        act_r = m_tdata_i;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, m_tdata_i);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (act_r.hit != exp_r.hit) begin
            $display("%0t: hit exp %0d act %0d", $time, exp_r.hit, act_r.hit);
            errors++;
          end
          if (act_r.frame != exp_r.frame) begin
            $display("%0t: frame exp %0d act %0d", $time, exp_r.frame, act_r.frame);
            errors++;
          end
          if (act_r.victim_valid != exp_r.victim_valid) begin
            $display("%0t: victim_valid exp %0d act %0d", $time,
                     exp_r.victim_valid, act_r.victim_valid);
            errors++;
          end
          if (act_r.evict_page != exp_r.evict_page) begin
            $display("%0t: evict_page exp %h act %h", $time,
                     exp_r.evict_page, act_r.evict_page);
            errors++;
          end
          if (act_r.victim_dirty != exp_r.victim_dirty) begin
            $display("%0t: victim_dirty exp %0d act %0d", $time,
                     exp_r.victim_dirty, act_r.victim_dirty);
            errors++;
          end
          if (act_r.pad != exp_r.pad) begin
            $display("%0t: upper bits exp %h act %h", $time, exp_r.pad, act_r.pad);
            errors++;
          end
        end
      end
    end
  end

endmodule

@@ dv/tb.sv @@
// Top of the page frame replacement testbench: clock, reset, APB register writes,
// access stimulus with random idling, and the verdict. Depends on pfr_pkg and pfr_checker.
`timescale 1ns / 1ps

module tb;
  import pfr_pkg::*;

  localparam int DRAIN_CYCLES = 2 * FRAMES + 16;
  localparam int STALL_LIMIT  = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          pending;
  int          errors;

  int          tx_idle_pct = 14;
  int          rx_idle_pct = 76;
  bit          long_hold_req = 0;
  bit          long_hold_used = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  logic [19:0] page_base;

  always #5 clk_i = ~clk_i;

  page_frame_replacement dut (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_tvalid), .s_tready_o(s_tready), .s_tdata_i(s_tdata), .s_tuser_i(s_tuser),
    .m_tvalid_o(m_tvalid), .m_tready_i(m_tready), .m_tdata_o(m_tdata),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  pfr_checker u_checker (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata), .s_tuser_i(s_tuser),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .pending_o(pending), .errors_o(errors)
  );

  // Result sink: random back-pressure plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (long_hold_req && !long_hold_used) begin
      long_hold_used = 1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_ni) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic reg_write(input logic [0:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_access(input logic [31:0] addr, input logic wr);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= addr;
    s_tuser  <= wr;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mostly a small working set around page_base so hits and evictions both occur.
  function automatic logic [31:0] pick_addr();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return {page_base ^ 20'($urandom_range(0, 23)), 12'($urandom)};
  endfunction

  initial begin
    int n_items;
    int phase_frames[7] = '{16, 1, 0, 31, 4, 8, 16};
    bit phase_policy[7] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    n_items = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: address extremes, dirty hit, fill past capacity under LRU.
    reg_write(REG_FRAMES, 32'd16);
    reg_write(REG_POLICY, 32'd0);
    send_access(32'h0000_0000, 1'b0);
    send_access(32'hFFFF_FFFF, 1'b1);
    send_access(32'h0000_0FFF, 1'b1);
    for (int i = 1; i <= 17; i++) send_access({20'(i * 4099), 12'h5A5}, i[0]);
    send_access(32'hFFFF_F000, 1'b0);
    drain();
    // Shrink the frame count with the table full, then sweep with the clock.
    reg_write(REG_FRAMES, 32'd3);
    reg_write(REG_POLICY, 32'd1);
    send_access(32'h0000_0000, 1'b1);
    send_access(32'h1234_5000, 1'b0);
    send_access(32'h0000_0000, 1'b0);
    drain();
    // Raise it again: frames kept above the old count come back, possibly as duplicates.
    reg_write(REG_FRAMES, 32'd16);
    send_access(32'h1234_5678, 1'b1);
    send_access(32'hFFFF_FABC, 1'b0);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      reg_write(REG_FRAMES, phase_frames[ph]);
      reg_write(REG_POLICY, 32'(phase_policy[ph]));
      page_base = 20'($urandom);
      for (int k = 0; k < 147; k++) begin
        if (n_items < 343) begin
          tx_idle_pct = 14;
          rx_idle_pct = 76;
        end else if (n_items < 686) begin
          tx_idle_pct = 76;
          rx_idle_pct = 14;
        end else begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        if (ph == 5 && k == 20) long_hold_req = 1;
        send_access(pick_addr(), 1'($urandom));
        n_items++;
      end
      drain();
    end

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
